// ===== hdl/marker_ink_canvas_with_bbox_top_defines.svh =====
// assertion macros for the marker ink canvas block
// used by the port checker; needs clk and rst in the including scope
`ifndef MARKER_INK_CANVAS_WITH_BBOX_TOP_DEFINES_SVH
`define MARKER_INK_CANVAS_WITH_BBOX_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mic_pkg.sv =====
// shared types and constants for the marker ink canvas block
// no dependencies
package mic_pkg;

  localparam int FRAME_WIDTH_DEF  = 1280;
  localparam int FRAME_HEIGHT_DEF = 720;

  localparam int ROW_W   = 10;
  localparam int COL_W   = 11;
  localparam int CHAN_W  = 8;
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CHAN_W-1:0] RED_THRESHOLD_RST = 8'd250;
  localparam logic [CHAN_W-1:0] BLUE_LIMIT_RST    = 8'd190;

  localparam logic [CFG_IDX_W-1:0] REG_RED_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LIMIT    = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MODIFY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             in_frame;
    logic             hit;
    logic [COL_W-1:0] col;
  } front_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
  } box_t;

endpackage

// ===== hdl/marker_ink_canvas_with_bbox_top.sv =====
// top level of the marker ink canvas with bounding box
// depends on mic_pkg, mic_ram, mic_front and mic_bbox
//
// Camera pixels come in on the slave stream; a pixel whose color passes the
// ink test (red above red_threshold, green below red, blue below green, red
// and blue_limit) sets a sticky bit in a one-bit canvas at the mirrored
// column and widens a bounding box. A clear transaction zeroes the canvas
// and empties the box; a read transaction returns one canvas bit. Every
// input transaction gives exactly one result transaction. The canvas lives
// in a single ram of 32-bit words, read, modified and written back one item
// at a time, so there are no overlapping accesses. A pixel or read item
// passes through address multiply, address add, ram read, modify/write
// and result load before the next item can be accepted, and its result is
// loaded once the result side is free; an item outside the frame or with
// the unused command goes straight to result load. A clear walks the ram one
// word a cycle over all ceil(FRAME_WIDTH*FRAME_HEIGHT/32) words, 28800 at
// 1280x720, then loads its result. The same walk runs after reset,
// during which no item is accepted; configuration writes are always taken.
module marker_ink_canvas_with_bbox_top #(
  parameter int FRAME_WIDTH  = mic_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = mic_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pix_row[9:0], pix_col[20:10], red[28:21], green[36:29], blue[44:37], zero pad
  input  logic [mic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [mic_pkg::CMD_W-1:0]       s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // ink_hit[0], canvas_bit[1], box_valid[2], box_left[13:3], box_right[24:14],
  // box_top[34:25], box_bottom[44:35], zero pad
  output logic [mic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mic_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mic_pkg::*;

  localparam int PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int DEPTH   = (PIXELS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W   = WADDR_W + BIT_W;

  // configuration registers
  logic [CHAN_W-1:0] red_threshold;
  logic [CHAN_W-1:0] blue_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_threshold <= RED_THRESHOLD_RST;
      blue_limit    <= BLUE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RED_THRESHOLD: red_threshold <= cfg_data;
        REG_BLUE_LIMIT:    blue_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [CHAN_W-1:0] in_red, in_green, in_blue;
  logic              in_acc;

  assign in_row   = s_axis_tdata[9:0];
  assign in_col   = s_axis_tdata[20:10];
  assign in_red   = s_axis_tdata[28:21];
  assign in_green = s_axis_tdata[36:29];
  assign in_blue  = s_axis_tdata[44:37];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  front_t front;

  mic_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .cmd          (s_axis_tuser),
    .pix_row      (in_row),
    .pix_col      (in_col),
    .red          (in_red),
    .green        (in_green),
    .blue         (in_blue),
    .red_threshold(red_threshold),
    .blue_limit   (blue_limit),
    .front        (front)
  );

  // control state
  state_t state, state_next;
  logic [WADDR_W-1:0] sweep;
  logic               sweep_emit;   // clear command waits for its result
  logic               sweep_last;

  // item registers
  logic [ROW_W-1:0] item_row;
  logic [COL_W-1:0] item_col;
  logic             item_hit;
  logic [LIN_W-1:0] prod;
  logic [LIN_W-1:0] lin;
  logic             res_hit;
  logic             res_bit;
  logic             out_free;

  assign sweep_last = (sweep == WADDR_W'(DEPTH - 1));
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep_last) state_next = sweep_emit ? ST_EMIT : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_t'(s_axis_tuser) == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (front.in_frame && (cmd_t'(s_axis_tuser) == CMD_PIXEL ||
                                          cmd_t'(s_axis_tuser) == CMD_READ)) begin
            state_next = ST_ADDR;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_ADDR:   state_next = ST_READ;
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // ram and control outputs
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  bit_mask;
  logic               old_bit;
  logic               box_clr;
  logic               box_upd;

  assign bit_mask = WORD_W'(1) << lin[BIT_W-1:0];
  assign old_bit  = ram_rdata[lin[BIT_W-1:0]];

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = lin[LIN_W-1:BIT_W];
    ram_wdata     = ram_rdata | bit_mask;
    ram_re        = 1'b0;
    box_clr       = 1'b0;
    box_upd       = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        box_clr       = in_acc && (cmd_t'(s_axis_tuser) == CMD_CLEAR);
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_MODIFY: begin
        ram_we  = item_hit;
        box_upd = item_hit;
      end
      default: ;
    endcase
  end

  mic_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH),
    .AW   (WADDR_W)
  ) u_canvas (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(lin[LIN_W-1:BIT_W]),
    .rdata(ram_rdata)
  );

  box_t box;

  mic_bbox u_bbox (
    .clk(clk),
    .rst(rst),
    .clr(box_clr),
    .upd(box_upd),
    .row(item_row),
    .col(item_col),
    .box(box)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      sweep         <= '0;
      sweep_emit    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep <= sweep + WADDR_W'(1);
      end else begin
        sweep <= '0;
      end
      if (state == ST_IDLE && in_acc) begin
        sweep_emit <= (cmd_t'(s_axis_tuser) == CMD_CLEAR);
      end
      if (state == ST_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      item_row <= in_row;
      item_col <= front.col;
      item_hit <= front.hit;
      prod     <= LIN_W'(in_row) * LIN_W'(FRAME_WIDTH);
      res_hit  <= 1'b0;
      res_bit  <= 1'b0;
    end
    if (state == ST_ADDR) begin
      lin <= prod + LIN_W'(item_col);
    end
    if (state == ST_MODIFY) begin
      res_hit <= item_hit;
      res_bit <= old_bit || item_hit;
    end
    if (state == ST_EMIT && out_free) begin
      m_axis_tdata <= {3'b000, box.bottom, box.top, box.right, box.left, box.valid,
                       res_bit, res_hit};
    end
  end

endmodule

// ===== hdl/mic_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mic_front.sv =====
// input classification: frame bounds, column mirroring and ink color test
// depends on mic_pkg
module mic_front #(
  parameter int FRAME_WIDTH  = mic_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = mic_pkg::FRAME_HEIGHT_DEF
) (
  input  logic [mic_pkg::CMD_W-1:0]  cmd,
  input  logic [mic_pkg::ROW_W-1:0]  pix_row,
  input  logic [mic_pkg::COL_W-1:0]  pix_col,
  input  logic [mic_pkg::CHAN_W-1:0] red,
  input  logic [mic_pkg::CHAN_W-1:0] green,
  input  logic [mic_pkg::CHAN_W-1:0] blue,
  input  logic [mic_pkg::CHAN_W-1:0] red_threshold,
  input  logic [mic_pkg::CHAN_W-1:0] blue_limit,
  output mic_pkg::front_t            front
);
  import mic_pkg::*;

  logic in_frame;
  logic color_ok;

  assign in_frame = ({1'b0, pix_row} < (ROW_W + 1)'(FRAME_HEIGHT)) &&
                    ({1'b0, pix_col} < (COL_W + 1)'(FRAME_WIDTH));

  assign color_ok = (red > red_threshold) && (green < red) && (blue < red) &&
                    (blue < green) && (blue < blue_limit);

  always_comb begin
    front.in_frame = in_frame;
    front.hit      = 1'b0;
    front.col      = pix_col;
    case (cmd_t'(cmd))
      CMD_PIXEL: begin
        // camera image is mirrored onto the canvas
        front.col = COL_W'(FRAME_WIDTH - 1) - pix_col;
        front.hit = in_frame && color_ok;
      end
      default: begin
        front.col = pix_col;
      end
    endcase
  end

endmodule

// ===== hdl/mic_bbox.sv =====
// running bounding box of inked canvas positions
// depends on mic_pkg
module mic_bbox (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      upd,
  input  logic [mic_pkg::ROW_W-1:0] row,
  input  logic [mic_pkg::COL_W-1:0] col,
  output mic_pkg::box_t             box
);
  import mic_pkg::*;

  box_t box_next;

  always_comb begin
    box_next = box;
    if (clr) begin
      box_next = '0;
    end else if (upd) begin
      if (!box.valid) begin
        box_next.valid  = 1'b1;
        box_next.left   = col;
        box_next.right  = col;
        box_next.top    = row;
        box_next.bottom = row;
      end else begin
        if (col < box.left) box_next.left = col;
        if (col > box.right) box_next.right = col;
        if (row < box.top) box_next.top = row;
        if (row > box.bottom) box_next.bottom = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else begin
      box <= box_next;
    end
  end

endmodule

// ===== hdl/mic_checker.sv =====
// port-level checker for the marker ink canvas block, bound to the top level
// depends on mic_pkg and marker_ink_canvas_with_bbox_top_defines.svh
`include "marker_ink_canvas_with_bbox_top_defines.svh"

module mic_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mic_pkg::*;

  // a stalled result keeps its payload
  `MIC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // an empty box reports all-zero coordinates
  `MIC_ASSERT_NOW(a_empty_box, m_axis_tvalid && !m_axis_tdata[2],
                  m_axis_tdata[44:3] == '0, "empty box with nonzero coordinates")

  // a filled box is ordered
  `MIC_ASSERT_NOW(a_box_order, m_axis_tvalid && m_axis_tdata[2],
                  (m_axis_tdata[13:3] <= m_axis_tdata[24:14]) &&
                  (m_axis_tdata[34:25] <= m_axis_tdata[44:35]), "box corners out of order")

  // an inked pixel leaves its bit set and the box filled
  `MIC_ASSERT_NOW(a_hit_marks, m_axis_tvalid && m_axis_tdata[0],
                  m_axis_tdata[1] && m_axis_tdata[2], "ink hit without canvas bit or box")

endmodule

bind marker_ink_canvas_with_bbox_top mic_checker u_mic_checker (.*);

// ===== tb/sv/marker_ink_canvas_with_bbox_top_test.sv =====
// self-checking testbench for marker_ink_canvas_with_bbox_top: a stream driver,
// a result monitor and a canvas/bounding box predictor checked field by field
// depends on mic_pkg and the block's rtl
`timescale 1ns / 1ps

module marker_ink_canvas_with_bbox_top_test;
  import mic_pkg::*;

  localparam int FW = FRAME_WIDTH_DEF;
  localparam int FH = FRAME_HEIGHT_DEF;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 222;
  localparam int SPOT_KEEP = 64;
  // the one command code the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_item_t;

  typedef struct {
    logic             ink_hit;
    logic             canvas_bit;
    logic             box_valid;
    logic [COL_W-1:0] box_left;
    logic [COL_W-1:0] box_right;
    logic [ROW_W-1:0] box_top;
    logic [ROW_W-1:0] box_bottom;
  } box_report_t;

  // canvas position known to have been inked (canvas column, not camera column)
  typedef struct {
    int row;
    int col;
  } spot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  marker_ink_canvas_with_bbox_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: thresholds, sparse canvas of set bits, running box
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0] red_thr  = RED_THRESHOLD_RST;
  logic [CHAN_W-1:0] blue_lim = BLUE_LIMIT_RST;
  bit               inked_bits[int];
  logic             have_ink  = 1'b0;
  logic [COL_W-1:0] ink_left  = '0;
  logic [COL_W-1:0] ink_right = '0;
  logic [ROW_W-1:0] ink_top   = '0;
  logic [ROW_W-1:0] ink_bottom = '0;

  pix_item_t   pixel_backlog[$];    // items waiting for the driver
  box_report_t pending_reports[$];  // expected results, oldest first
  spot_t       ink_spots[$];        // recent ink targets, reused for hits and reads
  int          idle_pct = 10;
  int          mismatch_count = 0;
  logic        in_taken = 1'b0;

  // applies one accepted item to the predictor and returns the result it owes
  function automatic box_report_t canvas_step(input pix_item_t it);
    box_report_t rep;
    int mcol;
    int addr;
    rep.ink_hit    = 1'b0;
    rep.canvas_bit = 1'b0;
    case (it.cmd)
      CMD_PIXEL: begin
        if (it.row < FH && it.col < FW) begin
          // the camera image is mirrored onto the canvas
          mcol = FW - 1 - int'(it.col);
          addr = int'(it.row) * FW + mcol;
          if (it.red > red_thr && it.green < it.red && it.blue < it.red &&
              it.blue < it.green && it.blue < blue_lim) begin
            rep.ink_hit = 1'b1;
            inked_bits[addr] = 1'b1;
            if (!have_ink) begin
              have_ink   = 1'b1;
              ink_left   = COL_W'(mcol);
              ink_right  = COL_W'(mcol);
              ink_top    = it.row;
              ink_bottom = it.row;
            end else begin
              if (mcol < ink_left)      ink_left   = COL_W'(mcol);
              if (mcol > ink_right)     ink_right  = COL_W'(mcol);
              if (it.row < ink_top)     ink_top    = it.row;
              if (it.row > ink_bottom)  ink_bottom = it.row;
            end
          end
          rep.canvas_bit = (inked_bits.exists(addr) != 0);
        end
      end
      CMD_CLEAR: begin
        inked_bits.delete();
        have_ink   = 1'b0;
        ink_left   = '0;
        ink_right  = '0;
        ink_top    = '0;
        ink_bottom = '0;
      end
      CMD_READ: begin
        // reads address the canvas directly, no mirroring
        if (it.row < FH && it.col < FW)
          rep.canvas_bit = (inked_bits.exists(int'(it.row) * FW + int'(it.col)) != 0);
      end
      default: begin
      end
    endcase
    rep.box_valid  = have_ink;
    rep.box_left   = ink_left;
    rep.box_right  = ink_right;
    rep.box_top    = ink_top;
    rep.box_bottom = ink_bottom;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic pix_item_t mk(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                   input int r, input int g, input int b);
    pix_item_t it;
    it.cmd   = cmd;
    it.row   = ROW_W'(row);
    it.col   = COL_W'(col);
    it.red   = CHAN_W'(r);
    it.green = CHAN_W'(g);
    it.blue  = CHAN_W'(b);
    return it;
  endfunction

  // colors that pass the ink test under the current thresholds, when any can
  function automatic void ink_colors(inout pix_item_t it);
    int lo;
    int top_b;
    if (red_thr == 8'd255 || blue_lim == 8'd0) begin
      it.red   = CHAN_W'($urandom_range(0, 255));
      it.green = CHAN_W'($urandom_range(0, 255));
      it.blue  = CHAN_W'($urandom_range(0, 255));
    end else begin
      lo = (int'(red_thr) + 1 > 2) ? int'(red_thr) + 1 : 2;
      it.red   = CHAN_W'($urandom_range(lo, 255));
      it.green = CHAN_W'($urandom_range(1, int'(it.red) - 1));
      top_b = (int'(it.green) - 1 < int'(blue_lim) - 1) ? int'(it.green) - 1
                                                        : int'(blue_lim) - 1;
      it.blue  = CHAN_W'($urandom_range(0, top_b));
    end
  endfunction

  function automatic pix_item_t random_item();
    pix_item_t it;
    spot_t     sp;
    int        pick;
    pick = $urandom_range(0, 99);
    it = mk(CMD_PIXEL, $urandom_range(0, FH - 1), $urandom_range(0, FW - 1),
            $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    if (pick < 2) begin
      it.cmd = CMD_UNUSED;
      it.row = ROW_W'($urandom_range(0, 1023));
      it.col = COL_W'($urandom_range(0, 2047));
    end else if (pick < 22) begin
      it.cmd = CMD_READ;
      if (ink_spots.size() != 0 && $urandom_range(0, 1) == 1) begin
        sp = ink_spots[$urandom_range(0, ink_spots.size() - 1)];
        it.row = ROW_W'(sp.row);
        it.col = COL_W'(sp.col);
      end else if ($urandom_range(0, 4) == 0) begin
        it.row = ROW_W'($urandom_range(0, 1023));
        it.col = COL_W'($urandom_range(0, 2047));
      end
    end else begin
      // pixel: mostly well-formed ink, some near misses, some noise
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        it.row = ROW_W'($urandom_range(0, 1023));
        it.col = COL_W'($urandom_range(0, 2047));
      end else if (pick < 40 && ink_spots.size() != 0) begin
        sp = ink_spots[$urandom_range(0, ink_spots.size() - 1)];
        it.row = ROW_W'(sp.row);
        it.col = COL_W'(FW - 1 - sp.col);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ink_colors(it);
        if (pick >= 60) begin
          case ($urandom_range(0, 3))
            0: it.red   = red_thr;
            1: it.green = it.red;
            2: it.blue  = it.green;
            default: it.blue = blue_lim;
          endcase
        end else if (it.row < FH && it.col < FW) begin
          sp.row = int'(it.row);
          sp.col = FW - 1 - int'(it.col);
          ink_spots.push_back(sp);
          if (ink_spots.size() > SPOT_KEEP) void'(ink_spots.pop_front());
        end
      end
    end
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RED_THRESHOLD: red_thr  = val;
      REG_BLUE_LIMIT:    blue_lim = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off until every queued item went in and every result came back
  task automatic drain();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s expected %0d got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: presents the next backlog item at the falling edge once the
  // previous transaction went through, with random gaps between items
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_pixels
    pix_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pixel_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        // pix_row, pix_col, red, green, blue from the lowest bit up
        s_axis_tdata  <= {3'b000, nxt.blue, nxt.green, nxt.red, nxt.col, nxt.row};
        s_axis_tuser  <= nxt.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // ---------------------------------------------------------------------------
  // input monitor: every accepted transaction goes through the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_pixels
    pix_item_t seen;
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      seen.cmd   = s_axis_tuser;
      seen.row   = s_axis_tdata[9:0];
      seen.col   = s_axis_tdata[20:10];
      seen.red   = s_axis_tdata[28:21];
      seen.green = s_axis_tdata[36:29];
      seen.blue  = s_axis_tdata[44:37];
      pending_reports.push_back(canvas_step(seen));
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compare against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    box_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no expectation outstanding");
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("ink_hit",    want.ink_hit,    m_axis_tdata[0]);
        check_field("canvas_bit", want.canvas_bit, m_axis_tdata[1]);
        check_field("box_valid",  want.box_valid,  m_axis_tdata[2]);
        check_field("box_left",   want.box_left,   m_axis_tdata[13:3]);
        check_field("box_right",  want.box_right,  m_axis_tdata[24:14]);
        check_field("box_top",    want.box_top,    m_axis_tdata[34:25]);
        check_field("box_bottom", want.box_bottom, m_axis_tdata[44:35]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    int thr_set[PHASES] = '{0, 255, 100, 250, 31, 128};
    int lim_set[PHASES] = '{255, 0, 200, 190, 255, 64};
    int clear_at;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset thresholds (red 250, blue 190)
    pixel_backlog.push_back(mk(CMD_READ,    0,    0,   0,   0,   0));  // empty canvas
    pixel_backlog.push_back(mk(CMD_PIXEL,   0,    0, 255, 200, 100));  // ink at far right
    pixel_backlog.push_back(mk(CMD_PIXEL, 719, 1279, 251, 250, 189));  // ink at far left
    pixel_backlog.push_back(mk(CMD_PIXEL,   5,    5, 250, 100,  50));  // red at threshold
    pixel_backlog.push_back(mk(CMD_PIXEL,   6,    6, 255, 255,  10));  // green equals red
    pixel_backlog.push_back(mk(CMD_PIXEL,   7,    7, 255, 100, 100));  // blue equals green
    pixel_backlog.push_back(mk(CMD_PIXEL,   8,    8, 255, 200, 190));  // blue at limit
    pixel_backlog.push_back(mk(CMD_PIXEL,   0,    0,   0,   0,   0));  // dark over old ink
    pixel_backlog.push_back(mk(CMD_PIXEL, 720,  100, 255, 200, 100));  // row off frame
    pixel_backlog.push_back(mk(CMD_PIXEL, 1023, 2047, 255, 254,  0));  // both off frame
    pixel_backlog.push_back(mk(CMD_PIXEL,   3, 1280, 255, 200, 100));  // column off frame
    pixel_backlog.push_back(mk(CMD_READ,  719,    0,   0,   0,   0));
    pixel_backlog.push_back(mk(CMD_READ,    0, 1279,   0,   0,   0));
    pixel_backlog.push_back(mk(CMD_READ,  720,    0,   0,   0,   0));
    pixel_backlog.push_back(mk(CMD_READ,    0, 1280,   0,   0,   0));
    pixel_backlog.push_back(mk(CMD_READ, 1023, 2047, 255, 255, 255));
    pixel_backlog.push_back(mk(CMD_UNUSED, 1023, 2047, 255, 255, 255));
    pixel_backlog.push_back(mk(CMD_PIXEL, 300,  640, 255, 128,   1));  // ink mid frame
    pixel_backlog.push_back(mk(CMD_CLEAR, 1023, 2047, 255, 255, 255));
    pixel_backlog.push_back(mk(CMD_READ,    0, 1279,   0,   0,   0));  // gone after clear
    pixel_backlog.push_back(mk(CMD_CLEAR,   0,    0,   0,   0,   0));  // clear when empty
    pixel_backlog.push_back(mk(CMD_PIXEL,  10,   20, 252,   3,   2));  // first ink again
    // sender waits here for every result before the first register write
    drain();

    // random phases, each under its own thresholds; one phase runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_RED_THRESHOLD, CFG_DATA_W'(thr_set[p]));
      write_reg(REG_BLUE_LIMIT, CFG_DATA_W'(lim_set[p]));
      idle_pct = (p == 2) ? 0 : 10;
      // a clear walks the whole canvas, so only one per phase
      clear_at = $urandom_range(0, PHASE_ITEMS - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == clear_at)
          pixel_backlog.push_back(mk(CMD_CLEAR, $urandom_range(0, 1023),
                                     $urandom_range(0, 2047), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 255)));
        else
          pixel_backlog.push_back(random_item());
      end
      drain();
    end

    // catch stray results after the last expected one
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, well above the slowest legal run including every canvas walk
  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
